FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // One stored entry.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   ext;
    entry_t new_ent;
  } cell_cmd_t;

endpackage

FILE: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares the new key and shifts left or right.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occ,
  input  logic      left_behind,
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  output logic      behind,
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  // The new entry goes behind this one when this slot is held and its key is not larger.
  assign behind = occ && (ent_r.key <= cmd.new_ent.key);
  assign ent    = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins && !behind) begin
      ent_nxt = left_behind ? cmd.new_ent : left_ent;
    end else if (cmd.ext) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: rtl/core/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded minimum priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in a row of cells kept in ascending
// priority order, the head in cell 0. On an insert each cell compares its key
// with the new one in parallel and either holds, takes the new entry, or takes
// its left neighbor's entry, so equal keys stay in arrival order; on an extract
// every cell takes its right neighbor's entry and the head's value is returned.
// The compare in each cell sets the cycle time. One result item comes back for
// each input item, registered at the output; a new item is taken in the same
// cycle that the previous result is taken, so the block sustains one item per
// clock as long as the receiver keeps taking results. An extract from an empty
// queue returns -1 with the empty status, and an insert into a full queue is
// dropped with the full status. The occupancy field carries the low five bits
// of the entry count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;

  logic      in_fire;
  logic      is_full;
  logic      is_empty;
  cell_cmd_t cmd;

  logic   behind [CAPACITY];
  entry_t ents   [CAPACITY];

  // The output register is free when empty or being drained this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd.ins           = in_fire && (in_item.action == ACT_INSERT) && !is_full;
    cmd.ext           = in_fire && (in_item.action == ACT_EXTRACT) && !is_empty;
    cmd.new_ent.value = in_item.value;
    cmd.new_ent.key   = in_item.priority_req;
  end

  // The chain itself. Cell 0 sees a virtual left neighbor that the new entry
  // always goes behind; the last cell keeps its own entry on an extract, which
  // then lies beyond the count and is never read.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   l_behind;
    entry_t l_ent;
    entry_t r_ent;

    if (i == 0) begin : g_head
      assign l_behind = 1'b1;
      assign l_ent    = cmd.new_ent;
    end else begin : g_body
      assign l_behind = behind[i-1];
      assign l_ent    = ents[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_ent = ents[i];
    end else begin : g_mid
      assign r_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (count_r > CNT_W'(i)),
      .left_behind (l_behind),
      .left_ent    (l_ent),
      .right_ent   (r_ent),
      .behind      (behind[i]),
      .ent         (ents[i])
    );
  end

  // Count update and the result item for the accepted item.
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.ext) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (in_fire) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.out_value = '0;
      out_item_nxt.status    = ST_DONE;
      out_item_nxt.occupancy = OCC_W'(count_nxt);
      if (in_item.action == ACT_INSERT) begin
        if (is_full) begin
          out_item_nxt.status = ST_FULL;
        end
      end else begin
        if (is_empty) begin
          out_item_nxt.out_value = EMPTY_VALUE;
          out_item_nxt.status    = ST_EMPTY;
        end else begin
          out_item_nxt.out_value = ents[0].value;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // The count never exceeds the number of cells.
  `ASSERT_RST(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY))
  // An insert that fits grows the count by exactly one.
  `ASSERT_RST(a_insert_grows, clk, rst_n, cmd.ins |=> count_r == $past(count_r) + 1'b1)
  // An empty result always carries the all-ones value.
  `ASSERT_RST(a_empty_value, clk, rst_n,
              (out_valid_r && out_item_r.status == ST_EMPTY) |->
              out_item_r.out_value == EMPTY_VALUE)
  // A pending result reports the occupancy the queue actually has.
  `ASSERT_RST(a_occ_match, clk, rst_n,
              out_valid_r |-> out_item_r.occupancy == OCC_W'(count_r))

endmodule

FILE: bench/sorted_priority_queue_core_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// Self-checking bench for the sorted priority queue core.
// ----------------------------------------------------------------------------
// A driver process offers insert and extract items from a pending list.
// A monitor process keeps a sorted shadow of the queue and predicts one
// result for every item the core takes. It then checks each result the core
// hands back against the oldest prediction. A directed opening covers these
// cases:
//   - an extract from an empty queue,
//   - the extreme keys and values,
//   - equal keys,
//   - a full queue that turns away an insert,
//   - a partial drain.
// Random runs follow. They switch between insert-heavy and extract-heavy
// runs, so the queue keeps swinging between empty and full. Both sides idle
// at random, and twice the receiver holds off for a long stretch, which
// backs the core up into its input.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned RANDOM_ITEMS  = 1876;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned DRAIN_CYCLES  = 8;

  // Key spreads used by the random part.
  localparam int unsigned KEYS_NARROW   = 0;
  localparam int unsigned KEYS_WIDE     = 1;
  localparam int unsigned KEYS_EXTREME  = 2;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Items waiting to be offered, and results predicted but not yet seen.
  in_item_t    pending_items[$];
  out_item_t   expected_results[$];

  // Sorted shadow copy of the queue contents, head at index 0.
  entry_t      shadow_entries[CAPACITY];
  int unsigned shadow_count = 0;

  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        hold_off = 1'b0;

  sorted_priority_queue_core #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length between items. Most gaps are short and a few are long.
  // Every fourth window of 150 items runs with no idling at all, so that
  // back-to-back traffic is covered too.
  function automatic int unsigned idle_gap(int unsigned index);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (((index / 150) % 4) == 3) begin
      return 0;
    end
    if (pick < 60) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Applies one item to the shadow queue and returns the result it causes.
  // An insert goes behind every entry whose key is lower or equal, so equal
  // keys leave in arrival order. An insert into a full queue is dropped, and
  // an extract from an empty one returns the all-ones value.
  function automatic out_item_t queue_step(in_item_t item);
    out_item_t   res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    res.status = ST_DONE;
    if (item.action == ACT_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count &&
               $signed(shadow_entries[pos].key) <= $signed(item.priority_req)) begin
          pos++;
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_entries[i] = shadow_entries[i-1];
        end
        shadow_entries[pos].value = item.value;
        shadow_entries[pos].key   = item.priority_req;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.out_value = EMPTY_VALUE;
        res.status    = ST_EMPTY;
      end else begin
        res.out_value = shadow_entries[0].value;
        for (i = 1; i < shadow_count; i++) begin
          shadow_entries[i-1] = shadow_entries[i];
        end
        shadow_count--;
      end
    end
    res.occupancy = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic in_item_t make_item(logic act, logic signed [DATA_W-1:0] val,
                                         logic signed [DATA_W-1:0] key);
    in_item_t item;
    item.action       = act;
    item.value        = val;
    item.priority_req = key;
    return item;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_key(int unsigned spread);
    logic signed [DATA_W-1:0] key;
    case (spread)
      KEYS_NARROW: begin
        key = $signed($urandom_range(0, 8)) - 4;
      end
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: key = 32'sh8000_0000;
          1: key = 32'sh7FFF_FFFF;
          2: key = 32'sd0;
          default: key = -32'sd1;
        endcase
      end
      default: begin
        key = $urandom;
      end
    endcase
    return key;
  endfunction

  // Driver. The next item goes out once the current one is taken and its
  // idle gap has run out. Each step sees only one assignment to in_valid,
  // so a valid that stays high across two items never dips.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = idle_gap(0);
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_gap(items_taken + 1);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here, started twice in the run. While it
  // lasts the sender keeps offering items, so the core has to stall its input.
  int unsigned hold_left = 0;
  int unsigned holds_started = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      hold_off <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if ((holds_started == 0 && items_taken >= 500) ||
                   (holds_started == 1 && items_taken >= 1400)) begin
        hold_left = HOLD_CYCLES;
        holds_started++;
      end
      hold_off <= (hold_left > 0);
    end
  end

  // Monitor. An item the core takes is predicted first. A result the core
  // hands back is then checked against the oldest prediction. The result is
  // registered inside the core, so it can never belong to the item taken at
  // this very edge.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    out_item_t expected;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(queue_step(in_item));
        items_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("Result with nothing expected: value %0d status %0d occupancy %0d",
                     out_item.out_value, out_item.status, out_item.occupancy);
          end
        end else begin
          expected = expected_results.pop_front();
          if (out_item.out_value !== expected.out_value ||
              out_item.status !== expected.status ||
              out_item.occupancy !== expected.occupancy) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("Result %0d mismatch: value %0d/%0d status %0d/%0d occupancy %0d/%0d",
                       results_seen, out_item.out_value, expected.out_value,
                       out_item.status, expected.status,
                       out_item.occupancy, expected.occupancy);
            end
          end
        end
        stall_left = idle_gap(results_seen);
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned made;
    int unsigned run_len;
    int unsigned insert_pct;
    int unsigned spread;
    int unsigned k;
    logic        act;

    // Directed opening. Start with an extract from the empty queue.
    pending_items.push_back(make_item(ACT_EXTRACT, 32'sh1234_5678, 32'sh0BAD_F00D));
    // Fill the queue. The set holds both extreme keys, extreme values and a
    // run of equal keys whose order on the way out shows arrival order.
    pending_items.push_back(make_item(ACT_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_items.push_back(make_item(ACT_INSERT, 32'sh8000_0000, 32'sh8000_0000));
    pending_items.push_back(make_item(ACT_INSERT, -32'sd1, 32'sd0));
    pending_items.push_back(make_item(ACT_INSERT, 32'sd0, -32'sd1));
    for (k = 0; k < 4; k++) begin
      pending_items.push_back(make_item(ACT_INSERT, 32'sd100 + k, 32'sd5));
    end
    pending_items.push_back(make_item(ACT_INSERT, 32'sh5555_5555, 32'sh8000_0000));
    pending_items.push_back(make_item(ACT_INSERT, 32'shAAAA_AAAA, 32'sh7FFF_FFFF));
    for (k = 0; k < 6; k++) begin
      pending_items.push_back(make_item(ACT_INSERT, $urandom, $urandom));
    end
    // The queue is full now, so this insert is turned away.
    pending_items.push_back(make_item(ACT_INSERT, 32'shDEAD_BEEF, 32'sh8000_0000));
    for (k = 0; k < 6; k++) begin
      pending_items.push_back(make_item(ACT_EXTRACT, $urandom, $urandom));
    end

    // Random runs. Each run leans toward inserts or toward extracts, so the
    // queue swings between empty and full. Ignored fields of extracts still
    // carry random bits.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      run_len = $urandom_range(20, 60);
      case ($urandom_range(0, 3))
        0: insert_pct = 25;
        1: insert_pct = 50;
        2: insert_pct = 75;
        default: insert_pct = 90;
      endcase
      spread = $urandom_range(KEYS_NARROW, KEYS_EXTREME);
      for (k = 0; k < run_len && made < RANDOM_ITEMS; k++) begin
        act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_EXTRACT;
        pending_items.push_back(make_item(act, $urandom, random_key(spread)));
        made++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait on the falling edge so that both clocked processes have settled.
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
bench/sorted_priority_queue_core_test.sv
